>>> hdl/assert_macros.svh
// Assertion macros for the RTL of the deadline job queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// The consequent holds whenever the antecedent holds.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/djq_pkg.sv
// Package with the constants and codes of the deadline job queue.
package djq_pkg;
   localparam int DJQ_QUEUE_DEPTH = 32;
   localparam int DJQ_TIME_BITS   = 40;
   localparam int DJQ_HANDLE_BITS = 8;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic KIND_ACK = 1'b0;
   localparam logic KIND_JOB = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;
endpackage

>>> hdl/deadline_job_queue_core.sv
// Top level of the deadline job queue: a sorted job store with timed release.
//
//   Channel  Direction  Payload
//   req      in         opcode, job_handle, due_time, now_time
//   rsp      out        kind, status, released_handle, released_time, last
//
// An add walks from the tail toward the head, reading each held job and moving it up one
// slot while its due time is later, then writes the new job; a full store acks with FULL.
// A tick reads from the head and releases each job that is due, one per response, through
// the registered read of the job RAM feeding the single shared time comparator.
// Reset empties the store at once; no clearing pass is needed.
// A stalled response holds its register; the sequencer waits for it to drain.
module deadline_job_queue_core
   import djq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DJQ_QUEUE_DEPTH,
   parameter int TIME_BITS   = DJQ_TIME_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_opcode,
   input  logic [DJQ_HANDLE_BITS-1:0] req_job_handle,
   input  logic [TIME_BITS-1:0]       req_due_time,
   input  logic [TIME_BITS-1:0]       req_now_time,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_kind,
   output logic                       rsp_status,
   output logic [DJQ_HANDLE_BITS-1:0] rsp_released_handle,
   output logic [TIME_BITS-1:0]       rsp_released_time,
   output logic                       rsp_last
);
`include "assert_macros.svh"

   localparam int IDXW       = $clog2(QUEUE_DEPTH);
   localparam int CNTW       = $clog2(QUEUE_DEPTH + 1);
   localparam int SUMW       = CNTW + 1;
   localparam int ENTRY_BITS = DJQ_HANDLE_BITS + TIME_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_STEP,
      S_ADD_CMP,
      S_ADD_ACK,
      S_TICK_READ,
      S_TICK_CMP,
      S_TICK_LAST
   } state_type;

   state_type             state_ff, state_in;
   logic [CNTW-1:0]       count_ff, count_in;
   logic [IDXW-1:0]       head_ff, head_in;
   logic [CNTW-1:0]       pos_ff, pos_in;
   logic [TIME_BITS-1:0]  key_ff, key_in;
   logic [ENTRY_BITS-1:0] job_ff, job_in;
   logic [ENTRY_BITS-1:0] hold_ff, hold_in;
   logic                  have_hold_ff, have_hold_in;
   logic                  full_ff, full_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_kind_ff, rsp_kind_in;
   logic                       rsp_status_ff, rsp_status_in;
   logic [DJQ_HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   logic [TIME_BITS-1:0]       rsp_time_ff, rsp_time_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                  ram_we, ram_re;
   logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata;
   logic [IDXW-1:0]       ram_addr;
   logic [CNTW-1:0]       lidx;
   logic [SUMW-1:0]       addr_sum;
   logic [IDXW-1:0]       head_next;
   logic                  key_gt;
   logic                  out_free;
   logic                  emit_ack, emit_job, emit_last;

   djq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH),
      .AW    (IDXW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   // The store is a ring starting at head; logical slots map onto RAM rows.
   assign addr_sum  = SUMW'(head_ff) + SUMW'(lidx);
   assign ram_addr  = (addr_sum >= SUMW'(QUEUE_DEPTH)) ?
                      IDXW'(addr_sum - SUMW'(QUEUE_DEPTH)) : IDXW'(addr_sum);
   assign head_next = (head_ff == IDXW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IDXW'(1);

   assign key_gt   = ram_rdata[TIME_BITS-1:0] > key_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      job_in       = job_ff;
      hold_in      = hold_ff;
      have_hold_in = have_hold_ff;
      full_in      = full_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_wdata    = job_ff;
      lidx         = '0;
      emit_ack     = 1'b0;
      emit_job     = 1'b0;
      emit_last    = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               job_in       = {req_job_handle, req_due_time};
               pos_in       = count_ff;
               have_hold_in = 1'b0;
               if (req_opcode == OP_ADD) begin
                  key_in   = req_due_time;
                  state_in = S_ADD_STEP;
               end else begin
                  key_in   = req_now_time;
                  state_in = S_TICK_READ;
               end
            end
         end
         S_ADD_STEP: begin
            if (count_ff == CNTW'(QUEUE_DEPTH)) begin
               full_in  = 1'b1;
               state_in = S_ADD_ACK;
            end else if (pos_ff == '0) begin
               ram_we   = 1'b1;
               count_in = count_ff + CNTW'(1);
               full_in  = 1'b0;
               state_in = S_ADD_ACK;
            end else begin
               ram_re   = 1'b1;
               lidx     = pos_ff - CNTW'(1);
               state_in = S_ADD_CMP;
            end
         end
         S_ADD_CMP: begin
            ram_we = 1'b1;
            lidx   = pos_ff;
            if (key_gt) begin
               ram_wdata = ram_rdata;
               pos_in    = pos_ff - CNTW'(1);
               state_in  = S_ADD_STEP;
            end else begin
               count_in = count_ff + CNTW'(1);
               full_in  = 1'b0;
               state_in = S_ADD_ACK;
            end
         end
         S_ADD_ACK: begin
            if (out_free) begin
               emit_ack = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_TICK_READ: begin
            if (count_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               ram_re   = 1'b1;
               state_in = S_TICK_CMP;
            end
         end
         S_TICK_CMP: begin
            if (!have_hold_ff || out_free) begin
               emit_job  = have_hold_ff;
               emit_last = key_gt;
               if (!key_gt) begin
                  hold_in      = ram_rdata;
                  have_hold_in = 1'b1;
                  head_in      = head_next;
                  count_in     = count_ff - CNTW'(1);
                  if (count_ff == CNTW'(1)) begin
                     state_in = S_TICK_LAST;
                  end else begin
                     ram_re = 1'b1;
                     lidx   = CNTW'(1);
                  end
               end else begin
                  have_hold_in = 1'b0;
                  state_in     = S_IDLE;
               end
            end
         end
         S_TICK_LAST: begin
            if (out_free) begin
               emit_job     = 1'b1;
               have_hold_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit_ack) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_ACK;
         rsp_status_in = full_ff ? STATUS_FULL : STATUS_OK;
         rsp_handle_in = '0;
         rsp_time_in   = '0;
         rsp_last_in   = 1'b1;
      end else if (emit_job) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_JOB;
         rsp_status_in = STATUS_OK;
         rsp_handle_in = hold_ff[ENTRY_BITS-1:TIME_BITS];
         rsp_time_in   = hold_ff[TIME_BITS-1:0];
         rsp_last_in   = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         have_hold_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         have_hold_ff <= have_hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      job_ff        <= job_in;
      hold_ff       <= hold_in;
      full_ff       <= full_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall           = state_ff != S_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_released_handle = rsp_handle_ff;
   assign rsp_released_time   = rsp_time_ff;
   assign rsp_last            = rsp_last_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNTW'(QUEUE_DEPTH))
   `ASSERT_IMPLIES(a_last_has_job, clock, reset, state_ff == S_TICK_LAST, have_hold_ff)
   `ASSERT_IMPLIES(a_release_due, clock, reset, emit_job, !(hold_ff[TIME_BITS-1:0] > key_ff))
endmodule

>>> hdl/djq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module djq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
